FILE: rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

  // Fixed field widths.
  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned REF_BITS    = 24;

  // Cells per first-level group of the match reduction tree.
  localparam int unsigned GROUP_SIZE = 64;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  // Sequencer commands broadcast to every cell of the row.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/skt_in_if.sv
`default_nettype none

interface skt_in_if import skt_pkg::*; #(
  parameter int unsigned KEY_BITS   = 24,
  parameter int unsigned BLOCK_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [OPCODE_BITS-1:0] opcode;
  logic [KEY_BITS-1:0]    key;
  logic [REF_BITS-1:0]    ref_name;
  logic [BLOCK_BITS-1:0]  block_id;

  modport source (output valid, opcode, key, ref_name, block_id, input ready);
  modport sink   (input valid, opcode, key, ref_name, block_id, output ready);
endinterface

`default_nettype wire

FILE: rtl/skt_out_if.sv
`default_nettype none

interface skt_out_if import skt_pkg::*; #(
  parameter int unsigned BLOCK_BITS = 16,
  parameter int unsigned COUNT_BITS = 9
) ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [REF_BITS-1:0]    found_ref_name;
  logic [BLOCK_BITS-1:0]  found_block_id;
  logic [COUNT_BITS-1:0]  entry_count;

  modport source (output valid, status, found_ref_name, found_block_id, entry_count,
                  input ready);
  modport sink   (input valid, status, found_ref_name, found_block_id, entry_count,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/sorted_key_table_insert_find.sv
// Sorted key table: a row of compare-and-shift cells, one entry per cell.
// Each request passes through accept, compare, group reduce, then final
// reduce with cell update; the update waits until the output register is
// free, and no new request is accepted before the sequencer is idle again.
// Reset: asynchronous, active low; the table becomes empty and no result is
// pending. Cell contents are not cleared and are never read while unused.
`default_nettype none

module sorted_key_table_insert_find import skt_pkg::*; #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned KEY_BITS   = 24,
  parameter int unsigned BLOCK_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  skt_in_if.sink     req_i,
  skt_out_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_GRP  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [OPCODE_BITS-1:0] op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [REF_BITS-1:0]    ref_q;
  logic [BLOCK_BITS-1:0]  blk_q;
  logic [CW-1:0]          count_q, count_d;

  logic                   out_valid_q;
  logic [STATUS_BITS-1:0] out_status_q, out_status_d;
  logic [REF_BITS-1:0]    out_ref_q, out_ref_d;
  logic [BLOCK_BITS-1:0]  out_blk_q, out_blk_d;
  logic [CW-1:0]          out_count_q;

  logic                   accept;
  logic                   load;
  logic                   ins_ok;
  cell_ctrl_t             ctrl;

  logic [KEY_BITS-1:0]    cell_key [CAPACITY];
  logic [REF_BITS-1:0]    cell_ref [CAPACITY];
  logic [BLOCK_BITS-1:0]  cell_blk [CAPACITY];
  logic                   cell_gt  [CAPACITY];
  logic [CAPACITY-1:0]    cell_eq;

  logic                   hit;
  logic [REF_BITS-1:0]    hit_ref;
  logic [BLOCK_BITS-1:0]  hit_blk;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Request register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.opcode;
      key_q <= req_i.key;
      ref_q <= req_i.ref_name;
      blk_q <= req_i.block_id;
    end
  end

  // Sequencer: compare, group reduce, then update once the output is free.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_CMP;
      S_CMP:  state_d = S_GRP;
      S_GRP:  state_d = S_UPD;
      S_UPD:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decide the outcome from the reduced match and the current fill level.
  always_comb begin
    load         = (state_q == S_UPD) && (!out_valid_q || rsp_o.ready);
    ins_ok       = (op_q == OP_INSERT) && !hit && (count_q != CAP_C);
    count_d      = count_q;
    out_status_d = ST_OK;
    out_ref_d    = '0;
    out_blk_d    = '0;
    case (op_q)
      OP_INSERT: begin
        if (hit) begin
          out_status_d = ST_DUP;
        end else if (count_q == CAP_C) begin
          out_status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      OP_FIND: begin
        if (hit) begin
          out_ref_d = hit_ref;
          out_blk_d = hit_blk;
        end else begin
          out_status_d = ST_MISS;
        end
      end
      OP_CLEAR: count_d = '0;
      default: count_d = count_q;
    endcase
    ctrl.cmp_en = (state_q == S_CMP);
    ctrl.ins_en = load && ins_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        count_q <= count_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register holds the result until the response transaction.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= out_status_d;
      out_ref_q    <= out_ref_d;
      out_blk_q    <= out_blk_d;
      out_count_q  <= count_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.found_ref_name = out_ref_q;
  assign rsp_o.found_block_id = out_blk_q;
  assign rsp_o.entry_count    = out_count_q;

  // Row of cells; during an insert, each cell whose left neighbor holds a larger key takes that entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      skt_cell #(
        .KEY_BITS  (KEY_BITS),
        .BLOCK_BITS(BLOCK_BITS),
        .CW        (CW),
        .IDX       (i)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .count_i   (count_q),
        .key_i     (key_q),
        .ref_i     (ref_q),
        .blk_i     (blk_q),
        .left_key_i(key_q),
        .left_ref_i(ref_q),
        .left_blk_i(blk_q),
        .left_gt_i (1'b0),
        .key_o     (cell_key[i]),
        .ref_o     (cell_ref[i]),
        .blk_o     (cell_blk[i]),
        .gt_o      (cell_gt[i]),
        .eq_o      (cell_eq[i])
      );
    end else begin : g_rest
      skt_cell #(
        .KEY_BITS  (KEY_BITS),
        .BLOCK_BITS(BLOCK_BITS),
        .CW        (CW),
        .IDX       (i)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .count_i   (count_q),
        .key_i     (key_q),
        .ref_i     (ref_q),
        .blk_i     (blk_q),
        .left_key_i(cell_key[i-1]),
        .left_ref_i(cell_ref[i-1]),
        .left_blk_i(cell_blk[i-1]),
        .left_gt_i (cell_gt[i-1]),
        .key_o     (cell_key[i]),
        .ref_o     (cell_ref[i]),
        .blk_o     (cell_blk[i]),
        .gt_o      (cell_gt[i]),
        .eq_o      (cell_eq[i])
      );
    end
  end

  // Match reduction: group results latch during the group-reduce step.
  skt_reduce #(
    .N         (CAPACITY),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_reduce (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (state_q == S_GRP),
    .eq_i  (cell_eq),
    .ref_i (cell_ref),
    .blk_i (cell_blk),
    .hit_o (hit),
    .ref_o (hit_ref),
    .blk_o (hit_blk)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("entry count exceeds capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == '0 || count_q == $past(count_q) + CW'(1)))
    else $error("entry count moved by more than one");

  a_count_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> (count_q == $past(count_q)))
    else $error("entry count changed outside an update");

  a_result_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_UPD))
    else $error("result appeared without an update step");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRP) |-> $onehot0(cell_eq))
    else $error("more than one cell matched the key");
`endif

endmodule

`default_nettype wire

FILE: rtl/skt_cell.sv
`default_nettype none

module skt_cell import skt_pkg::*; #(
  parameter int unsigned KEY_BITS   = 24,
  parameter int unsigned BLOCK_BITS = 16,
  parameter int unsigned CW         = 9,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [CW-1:0]         count_i,
  input  wire logic [KEY_BITS-1:0]   key_i,
  input  wire logic [REF_BITS-1:0]   ref_i,
  input  wire logic [BLOCK_BITS-1:0] blk_i,
  input  wire logic [KEY_BITS-1:0]   left_key_i,
  input  wire logic [REF_BITS-1:0]   left_ref_i,
  input  wire logic [BLOCK_BITS-1:0] left_blk_i,
  input  wire logic                  left_gt_i,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [REF_BITS-1:0]        ref_o,
  output logic [BLOCK_BITS-1:0]      blk_o,
  output logic                       gt_o,
  output logic                       eq_o
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [KEY_BITS-1:0]   key_q;
  logic [REF_BITS-1:0]   ref_q;
  logic [BLOCK_BITS-1:0] blk_q;
  logic                  gt_q, gt_d;
  logic                  eq_q, eq_d;
  logic                  used;

  // Compare the held entry against the search key; only occupied cells count.
  always_comb begin
    used = IDX_C < count_i;
    gt_d = used && (key_q > key_i);
    eq_d = used && (key_q == key_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      gt_q <= gt_d;
      eq_q <= eq_d;
    end
  end

  // On insert, larger entries move up one cell and the first free or
  // first larger cell takes the new entry.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en) begin
      if (left_gt_i) begin
        key_q <= left_key_i;
        ref_q <= left_ref_i;
        blk_q <= left_blk_i;
      end else if (gt_q || (IDX_C == count_i)) begin
        key_q <= key_i;
        ref_q <= ref_i;
        blk_q <= blk_i;
      end
    end
  end

  assign key_o = key_q;
  assign ref_o = ref_q;
  assign blk_o = blk_q;
  assign gt_o  = gt_q;
  assign eq_o  = eq_q;

endmodule

`default_nettype wire

FILE: rtl/skt_reduce.sv
`default_nettype none

module skt_reduce import skt_pkg::*; #(
  parameter int unsigned N          = 256,
  parameter int unsigned BLOCK_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic [N-1:0]          eq_i,
  input  wire logic [REF_BITS-1:0]   ref_i [N],
  input  wire logic [BLOCK_BITS-1:0] blk_i [N],
  output logic                       hit_o,
  output logic [REF_BITS-1:0]        ref_o,
  output logic [BLOCK_BITS-1:0]      blk_o
);

  localparam int unsigned NG = (N + GROUP_SIZE - 1) / GROUP_SIZE;

  logic                  grp_hit_d [NG];
  logic [REF_BITS-1:0]   grp_ref_d [NG];
  logic [BLOCK_BITS-1:0] grp_blk_d [NG];
  logic                  grp_hit_q [NG];
  logic [REF_BITS-1:0]   grp_ref_q [NG];
  logic [BLOCK_BITS-1:0] grp_blk_q [NG];

  // First level: AND-OR select inside each group. Keys are unique, so at
  // most one cell matches.
  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int unsigned BASE = g * GROUP_SIZE;
    localparam int unsigned LEN  = (N - BASE < GROUP_SIZE) ? N - BASE : GROUP_SIZE;

    always_comb begin
      grp_hit_d[g] = 1'b0;
      grp_ref_d[g] = '0;
      grp_blk_d[g] = '0;
      for (int j = 0; j < LEN; j++) begin
        grp_hit_d[g] = grp_hit_d[g] | eq_i[BASE + j];
        grp_ref_d[g] = grp_ref_d[g] | (eq_i[BASE + j] ? ref_i[BASE + j] : '0);
        grp_blk_d[g] = grp_blk_d[g] | (eq_i[BASE + j] ? blk_i[BASE + j] : '0);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        grp_hit_q[g] <= 1'b0;
      end else if (en_i) begin
        grp_hit_q[g] <= grp_hit_d[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        grp_ref_q[g] <= grp_ref_d[g];
        grp_blk_q[g] <= grp_blk_d[g];
      end
    end
  end

  // Second level: OR across the registered group results.
  always_comb begin
    hit_o = 1'b0;
    ref_o = '0;
    blk_o = '0;
    for (int g = 0; g < NG; g++) begin
      hit_o = hit_o | grp_hit_q[g];
      ref_o = ref_o | grp_ref_q[g];
      blk_o = blk_o | grp_blk_q[g];
    end
  end

endmodule

`default_nettype wire
